// File: src/bldv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldv_pkg: shared definitions for the bounded list
// Sizes, operation and status codes, cell commands and word conversions.
// ----------------------------------------------------------------------------
package bldv_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);

	typedef logic [DATA_WIDTH-1:0] word_t;

	// Operation codes carried in the request.
	localparam logic [2:0] OP_INS_REAR  = 3'd0;
	localparam logic [2:0] OP_INS_FRONT = 3'd1;
	localparam logic [2:0] OP_DEL_REAR  = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_VAL   = 3'd4;
	localparam logic [2:0] OP_READ_OUT  = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Commands broadcast to every cell.
	localparam logic [2:0] CMD_NONE       = 3'd0;
	localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
	localparam logic [2:0] CMD_DEL_REAR   = 3'd3;
	localparam logic [2:0] CMD_DEL_FRONT  = 3'd4;
	localparam logic [2:0] CMD_DEL_VAL    = 3'd5;
	localparam logic [2:0] CMD_ROTATE     = 3'd6;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [CNT_W-1:0] cnt;
	} cell_ctl_t;

	// Sign-extend the 32-bit request word, then keep the stored width.
	function automatic word_t from_in(input logic [31:0] v);
		logic signed [63:0] t;
		t = 64'(signed'(v));
		return t[DATA_WIDTH-1:0];
	endfunction

	// Sign-extend a stored word and keep the low 32 bits for the result.
	function automatic logic [31:0] to_out(input word_t w);
		logic signed [63:0] t;
		t = 64'(signed'(w));
		return t[31:0];
	endfunction

endpackage

// File: src/bldv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldv_cell: one list position
// Holds one word, compares it with the search value and shifts to or from
// its neighbours as the broadcast command says.
// ----------------------------------------------------------------------------
module bldv_cell (
	input  logic                     clk,
	input  logic [bldv_pkg::IDX_W-1:0] idx,
	input  bldv_pkg::cell_ctl_t      ctl,
	input  bldv_pkg::word_t          val,
	input  bldv_pkg::word_t          left_data,
	input  bldv_pkg::word_t          right_data,
	input  bldv_pkg::word_t          front_data,
	input  logic                     hit_in,
	input  bldv_pkg::word_t          pick_in,
	output logic                     hit_out,
	output bldv_pkg::word_t          pick_out,
	output bldv_pkg::word_t          data
);
	import bldv_pkg::*;

	word_t            data_q;
	word_t            data_nxt;
	logic [CNT_W-1:0] pos;
	logic             in_use;
	logic             is_rear;
	logic             eq;
	logic             sel;

	assign pos     = CNT_W'(idx);
	assign in_use  = pos < ctl.cnt;
	assign is_rear = pos == (ctl.cnt - CNT_W'(1));
	assign eq      = in_use && (data_q == val);
	assign hit_out = hit_in | eq;

	// The first matching cell, or the cell at the end being removed, drives
	// its word onto the pick chain.
	assign sel = ((ctl.cmd == CMD_DEL_REAR) && is_rear) ||
	             ((ctl.cmd == CMD_DEL_FRONT) && (idx == '0)) ||
	             ((ctl.cmd == CMD_DEL_VAL) && eq && !hit_in);
	assign pick_out = pick_in | (sel ? data_q : '0);
	assign data     = data_q;

	always_comb begin
		data_nxt = data_q;
		unique case (ctl.cmd)
			CMD_PUSH_REAR:  if (pos == ctl.cnt) data_nxt = val;
			CMD_PUSH_FRONT: data_nxt = (idx == '0) ? val : left_data;
			CMD_DEL_FRONT:  data_nxt = right_data;
			CMD_DEL_VAL:    if (hit_in || eq) data_nxt = right_data;
			CMD_ROTATE:     data_nxt = is_rear ? front_data : right_data;
			default:        data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

endmodule

// File: src/bldv_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldv_chain: row of list cells
// Links the cells front to rear and gathers the match and pick chains.
// ----------------------------------------------------------------------------
module bldv_chain (
	input  logic                clk,
	input  bldv_pkg::cell_ctl_t ctl,
	input  bldv_pkg::word_t     val,
	output logic                any_hit,
	output bldv_pkg::word_t     pick_data,
	output bldv_pkg::word_t     front_data
);
	import bldv_pkg::*;

	word_t cell_data [DEPTH];
	logic  hit_link  [DEPTH+1];
	word_t pick_link [DEPTH+1];

	assign hit_link[0]  = 1'b0;
	assign pick_link[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = val;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		bldv_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctl       (ctl),
			.val       (val),
			.left_data (left_w),
			.right_data(right_w),
			.front_data(cell_data[0]),
			.hit_in    (hit_link[i]),
			.pick_in   (pick_link[i]),
			.hit_out   (hit_link[i+1]),
			.pick_out  (pick_link[i+1]),
			.data      (cell_data[i])
		);
	end

	assign any_hit    = hit_link[DEPTH];
	assign pick_data  = pick_link[DEPTH];
	assign front_data = cell_data[0];

endmodule

// File: src/bounded_list_with_value_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_with_value_delete_top: bounded ordered list of signed words
// Request decode, entry count, read-out sequencing and the result register.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one word per cell, with the front
// in cell 0. Inserts, deletes at either end and deletes by value each act on
// the whole row: every cell compares its word with the request value at
// once, a ripple of match flags finds the first hit, and the cells behind it
// shift forward in the same edge. A request is taken whenever the block is
// not reading out and the result register is free or being emptied, so with
// a ready sink these requests flow at one per cycle. A read out of N entries
// produces N results, one per cycle when the output is free, by rotating the
// row through cell 0; it blocks new requests until the last result is out
// and leaves the list as it was. Op codes 6 and 7 are accepted and produce
// no result. Status codes: 0 ok, 1 empty, 2 value not found, 3 store full.
// ----------------------------------------------------------------------------
module bounded_list_with_value_delete_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [7:0]  s_tuser,   // [2:0] op, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data_out
	output logic [7:0]  m_tuser,   // [1:0] status, rest zero
	output logic        m_tlast
);
	import bldv_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_left_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [31:0]      out_data_q;
	logic             out_last_q;

	logic             out_free;
	logic             accept;
	logic [2:0]       op;
	word_t            val;
	cell_ctl_t        ctl;
	logic             any_hit;
	word_t            pick_data;
	word_t            front_data;

	logic             load_out;
	logic [1:0]       nxt_status;
	logic [31:0]      nxt_data;
	logic             nxt_last;
	logic [CNT_W-1:0] count_nxt;
	logic             start_rd;
	logic             rd_step;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !busy_q && out_free;
	assign accept   = s_tvalid && s_tready;
	assign op       = s_tuser[2:0];
	assign val      = from_in(s_tdata);
	assign rd_step  = busy_q && out_free;

	bldv_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.val       (val),
		.any_hit   (any_hit),
		.pick_data (pick_data),
		.front_data(front_data)
	);

	// Decode the request into a cell command and the result it produces.
	always_comb begin
		ctl.cmd    = CMD_NONE;
		ctl.cnt    = count_q;
		load_out   = 1'b0;
		nxt_status = ST_OK;
		nxt_data   = '0;
		nxt_last   = 1'b1;
		count_nxt  = count_q;
		start_rd   = 1'b0;
		if (rd_step) begin
			ctl.cmd  = CMD_ROTATE;
			load_out = 1'b1;
			nxt_data = to_out(front_data);
			nxt_last = rd_left_q == CNT_W'(1);
		end else if (accept) begin
			unique case (op) inside
				OP_INS_REAR, OP_INS_FRONT: begin
					load_out = 1'b1;
					if (count_q == CNT_W'(DEPTH)) begin
						nxt_status = ST_FULL;
					end else begin
						ctl.cmd   = (op == OP_INS_REAR) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				OP_DEL_REAR, OP_DEL_FRONT, OP_DEL_VAL: begin
					load_out = 1'b1;
					if (count_q == '0) begin
						nxt_status = ST_EMPTY;
					end else begin
						ctl.cmd = (op == OP_DEL_REAR)  ? CMD_DEL_REAR :
						          (op == OP_DEL_FRONT) ? CMD_DEL_FRONT : CMD_DEL_VAL;
						if (op == OP_DEL_VAL && !any_hit) begin
							nxt_status = ST_NOTFOUND;
						end else begin
							nxt_data  = to_out(pick_data);
							count_nxt = count_q - CNT_W'(1);
						end
					end
				end
				OP_READ_OUT: begin
					if (count_q == '0) begin
						load_out   = 1'b1;
						nxt_status = ST_EMPTY;
					end else begin
						start_rd = 1'b1;
					end
				end
				default: begin
					load_out = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rd_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (start_rd) begin
				busy_q    <= 1'b1;
				rd_left_q <= count_q;
			end else if (rd_step) begin
				rd_left_q <= rd_left_q - CNT_W'(1);
				if (rd_left_q == CNT_W'(1)) busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload carries no reset; it is qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= nxt_status;
			out_data_q   <= nxt_data;
			out_last_q   <= nxt_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {6'b0, out_status_q};
	assign m_tlast  = out_last_q;

	// The entry count never passes the size of the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond store size");

	// A read out only runs over a non-empty list with entries still to go.
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rd_left_q != '0) && (rd_left_q <= count_q))
		else $error("read-out counter out of range");

	// Sending the final element of a read out ends it.
	a_rd_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_step && rd_left_q == CNT_W'(1)) |=> !busy_q && m_tlast)
		else $error("read out did not end on its final element");

	// A refused insert into a full store leaves the count alone.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_INS_REAR || op == OP_INS_FRONT) &&
		 count_q == CNT_W'(DEPTH)) |=> $stable(count_q) && m_tuser[1:0] == ST_FULL)
		else $error("insert into full store changed the list");

	// The count stays put during a read out.
	a_rd_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && $past(busy_q)) |-> $stable(count_q))
		else $error("count changed during read out");

endmodule
